>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// ASSERT_RST checks a property only while reset is released.
// ASSERT_ALWAYS checks a property at every rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> rtl/tkd_pkg.sv
package tkd_pkg;

    // Width of all timestamps and elapsed-time arithmetic.
    localparam int TIME_BITS = 32;
    typedef logic [TIME_BITS-1:0] time_t;

    // Event codes reported on the result channel.
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_UP     = 3'd1;
    localparam logic [2:0] EV_SELECT = 3'd2;
    localparam logic [2:0] EV_DOWN   = 3'd3;
    localparam logic [2:0] EV_BACK   = 3'd4;

    // Button positions in the level vectors.
    localparam int KEY_UP     = 0;
    localparam int KEY_SELECT = 1;
    localparam int KEY_DOWN   = 2;

    // Configuration register indexes.
    localparam logic CFG_DEBOUNCE  = 1'b0;
    localparam logic CFG_LONGPRESS = 1'b1;

    // One input item as held in the input register.
    typedef struct packed {
        logic        func;
        logic [31:0] now_ms;
        logic [2:0]  level;
    } item_t;

    // Configuration values as seen by the poll logic.
    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] longpress_ms;
    } cfg_t;

    // Complete qualifier state.
    typedef struct packed {
        logic            ready;
        logic [2:0]      sampled;
        logic [2:0]      stable;
        logic            long_reported;
        time_t [2:0]     last_change;
        time_t           select_press;
    } state_t;

    // Outcome of evaluating one button against its own state.
    typedef struct packed {
        logic       sampled;
        logic       stable;
        time_t      last_change;
        logic       long_reported;
        time_t      select_press;
        logic [2:0] ev;
    } key_res_t;

    // Evaluate one button: debounce, stable edge and, for select, long press.
    function automatic key_res_t key_step(
        input logic        is_sel,
        input logic [2:0]  press_ev,
        input logic        level,
        input logic        sampled,
        input logic        stable,
        input time_t       last_change,
        input logic        long_rep,
        input time_t       sel_press,
        input time_t       now,
        input logic [15:0] deb,
        input logic [15:0] lp
    );
        key_res_t r;
        time_t    lct_n;
        logic     check_long;
        r.sampled = level;
        lct_n = (level != sampled) ? now : last_change;
        r.last_change = lct_n;
        r.stable = stable;
        r.long_reported = long_rep;
        r.select_press = sel_press;
        r.ev = EV_NONE;
        check_long = 1'b0;
        if ((now - lct_n) >= time_t'(deb)) begin
            r.stable = level;
            if (level != stable) begin
                if (level) begin
                    if (is_sel) begin
                        r.select_press = now;
                        r.long_reported = 1'b0;
                        check_long = 1'b1;
                    end else begin
                        r.ev = press_ev;
                    end
                end else if (is_sel && !long_rep) begin
                    r.ev = EV_SELECT;
                end
            end else begin
                check_long = is_sel;
            end
            // Long press reports back once while select stays held.
            if (check_long && r.stable && !r.long_reported &&
                ((now - r.select_press) >= time_t'(lp))) begin
                r.long_reported = 1'b1;
                r.ev = EV_BACK;
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/three_key_debounce_longpress_top.sv
// Three-button keypad qualifier with debounce and a long-press back event.
// Input channel (s_valid/s_ready): one transfer per item; s_func 0 captures
// the current levels as debounced state, s_func 1 polls for an event with
// the millisecond timestamp s_now_ms and the three pressed levels.
// Result channel (m_valid/m_ready): exactly one transfer per input item,
// m_key_event 0 none, 1 up, 2 select, 3 down, 4 back, in input order.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr
// (0 debounce_ms, 1 longpress_ms); write only while the block is idle.
// Path: an accepted item waits in the input register, and its result is
// then held in the result register. Throughput: one item per cycle while
// m_ready stays high, set by the state update between the two registers.
// When m_ready is low, the result register holds and the input register
// still takes one more item; s_ready then drops until the result moves.
// Reset (aresetn low, synchronous) empties both registers, restores the
// default configuration and returns the keypad to the not-initialized state,
// in which polls report no event.
`include "assert_macros.svh"

module three_key_debounce_longpress_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [31:0] s_now_ms,
    input  logic        s_up_pressed,
    input  logic        s_select_pressed,
    input  logic        s_down_pressed,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_key_event,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata
);

    logic             in_valid_reg;
    logic             in_valid_next;
    tkd_pkg::item_t   in_item_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [2:0]       out_event_reg;
    tkd_pkg::state_t  state_reg;
    tkd_pkg::state_t  state_next;
    tkd_pkg::state_t  poll_state;
    logic [2:0]       poll_event;
    tkd_pkg::cfg_t    cfg_reg;
    tkd_pkg::cfg_t    cfg_next;
    logic             s_xfer;
    logic             advance;

    // Handshake: the item moves on when the result register is free or draining.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_xfer = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_key_event = out_event_reg;

    assign in_valid_next = s_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    assign state_next = advance ? poll_state : state_reg;

    // Configuration write port.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                tkd_pkg::CFG_DEBOUNCE:  cfg_next.debounce_ms = cfg_wdata;
                tkd_pkg::CFG_LONGPRESS: cfg_next.longpress_ms = cfg_wdata;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    tkd_poll u_poll (
        .item       (in_item_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (poll_state),
        .key_event  (poll_event)
    );

    // Control and keypad state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg <= '0;
            cfg_reg.debounce_ms <= 16'd50;
            cfg_reg.longpress_ms <= 16'd1000;
        end else begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg <= state_next;
            cfg_reg <= cfg_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_item_reg.func <= s_func;
            in_item_reg.now_ms <= s_now_ms;
            in_item_reg.level <= {s_down_pressed, s_select_pressed, s_up_pressed};
        end
        if (advance) begin
            out_event_reg <= poll_event;
        end
    end

    `ASSERT_RST(a_early_poll_keeps_state, aclk, aresetn,
        (advance && in_item_reg.func && !state_reg.ready) |=> (state_reg == $past(state_reg)),
        "poll before init changed the keypad state")
    `ASSERT_RST(a_long_flag_with_back, aclk, aresetn,
        $rose(state_reg.long_reported) |-> (out_valid_reg && (out_event_reg == tkd_pkg::EV_BACK)),
        "long-press flag set without a back event")
    `ASSERT_RST(a_event_needs_init, aclk, aresetn,
        (out_valid_reg && (out_event_reg != tkd_pkg::EV_NONE)) |-> state_reg.ready,
        "event reported before init")

endmodule

>>> rtl/tkd_poll.sv
module tkd_poll (
    input  tkd_pkg::item_t  item,
    input  tkd_pkg::cfg_t   cfg,
    input  tkd_pkg::state_t state,
    output tkd_pkg::state_t state_next,
    output logic [2:0]      key_event
);

    tkd_pkg::time_t    now;
    tkd_pkg::key_res_t res_up;
    tkd_pkg::key_res_t res_sel;
    tkd_pkg::key_res_t res_dn;

    assign now = tkd_pkg::time_t'(item.now_ms);

    // All three buttons are evaluated in parallel; each only touches its own state.
    always_comb begin
        res_up = tkd_pkg::key_step(1'b0, tkd_pkg::EV_UP,
            item.level[tkd_pkg::KEY_UP], state.sampled[tkd_pkg::KEY_UP],
            state.stable[tkd_pkg::KEY_UP], state.last_change[tkd_pkg::KEY_UP],
            state.long_reported, state.select_press, now,
            cfg.debounce_ms, cfg.longpress_ms);
        res_sel = tkd_pkg::key_step(1'b1, tkd_pkg::EV_SELECT,
            item.level[tkd_pkg::KEY_SELECT], state.sampled[tkd_pkg::KEY_SELECT],
            state.stable[tkd_pkg::KEY_SELECT], state.last_change[tkd_pkg::KEY_SELECT],
            state.long_reported, state.select_press, now,
            cfg.debounce_ms, cfg.longpress_ms);
        res_dn = tkd_pkg::key_step(1'b0, tkd_pkg::EV_DOWN,
            item.level[tkd_pkg::KEY_DOWN], state.sampled[tkd_pkg::KEY_DOWN],
            state.stable[tkd_pkg::KEY_DOWN], state.last_change[tkd_pkg::KEY_DOWN],
            state.long_reported, state.select_press, now,
            cfg.debounce_ms, cfg.longpress_ms);
    end

    // Init captures the levels; a poll commits buttons in priority order
    // up to and including the first one that reports an event.
    always_comb begin
        state_next = state;
        key_event = tkd_pkg::EV_NONE;
        priority if (!item.func) begin
            state_next.ready = 1'b1;
            state_next.sampled = item.level;
            state_next.stable = item.level;
            state_next.last_change = {3{now}};
            state_next.long_reported = 1'b0;
            state_next.select_press = '0;
        end else if (state.ready) begin
            state_next.sampled[tkd_pkg::KEY_UP] = res_up.sampled;
            state_next.stable[tkd_pkg::KEY_UP] = res_up.stable;
            state_next.last_change[tkd_pkg::KEY_UP] = res_up.last_change;
            key_event = res_up.ev;
            if (res_up.ev == tkd_pkg::EV_NONE) begin
                state_next.sampled[tkd_pkg::KEY_SELECT] = res_sel.sampled;
                state_next.stable[tkd_pkg::KEY_SELECT] = res_sel.stable;
                state_next.last_change[tkd_pkg::KEY_SELECT] = res_sel.last_change;
                state_next.long_reported = res_sel.long_reported;
                state_next.select_press = res_sel.select_press;
                key_event = res_sel.ev;
                if (res_sel.ev == tkd_pkg::EV_NONE) begin
                    state_next.sampled[tkd_pkg::KEY_DOWN] = res_dn.sampled;
                    state_next.stable[tkd_pkg::KEY_DOWN] = res_dn.stable;
                    state_next.last_change[tkd_pkg::KEY_DOWN] = res_dn.last_change;
                    key_event = res_dn.ev;
                end
            end
        end else begin
            // A poll before init leaves everything untouched.
            key_event = tkd_pkg::EV_NONE;
        end
    end

endmodule

>>> sim/keypad_checker.sv
`timescale 1ns / 100ps

module keypad_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_func,
    input  logic [31:0] s_now_ms,
    input  logic        s_up_pressed,
    input  logic        s_select_pressed,
    input  logic        s_down_pressed,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_key_event,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,
    output int          pending,
    output int          errors,
    output int          checked,
    output int          key_events
);
    import tkd_pkg::*;

    localparam logic [15:0] DEBOUNCE_AFTER_RESET  = 16'd50;
    localparam logic [15:0] LONGPRESS_AFTER_RESET = 16'd1000;

    // Configuration as last written.
    logic [15:0] debounce_ms;
    logic [15:0] longpress_ms;

    // Keypad state kept alongside the block.
    logic        keypad_ready;
    logic [2:0]  sampled_lvl;
    logic [2:0]  stable_lvl;
    logic        long_done;
    time_t       change_time [3];
    time_t       press_time;

    // Key events still owed by the block, oldest first.
    logic [2:0]  owed_events [$];

    int          error_count = 0;
    int          result_count = 0;
    int          event_count = 0;

    // Debounce one button and return the event it raises, if any.
    function automatic logic [2:0] debounce_key(input int k, input logic lvl, input time_t now);
        if (lvl != sampled_lvl[k]) begin
            sampled_lvl[k] = lvl;
            change_time[k] = now;
        end
        if (time_t'(now - change_time[k]) < time_t'(debounce_ms)) begin
            return EV_NONE;
        end
        if (lvl != stable_lvl[k]) begin
            stable_lvl[k] = lvl;
            // Up and down fire on press; select fires on release unless back was sent.
            if (lvl && k != KEY_SELECT) begin
                return (k == KEY_UP) ? EV_UP : EV_DOWN;
            end
            if (!lvl) begin
                return (k == KEY_SELECT && !long_done) ? EV_SELECT : EV_NONE;
            end
            press_time = now;
            long_done  = 1'b0;
        end
        // A held select turns into back once the long-press time has passed.
        if (k == KEY_SELECT && stable_lvl[KEY_SELECT] && !long_done &&
            time_t'(now - press_time) >= time_t'(longpress_ms)) begin
            long_done = 1'b1;
            return EV_BACK;
        end
        return EV_NONE;
    endfunction

    // Work out the key event for one transfer and advance the keypad state.
    function automatic logic [2:0] qualify_item(input logic poll, input time_t now,
                                                input logic [2:0] lvl);
        logic [2:0] ev;
        ev = EV_NONE;
        if (!poll) begin
            sampled_lvl  = lvl;
            stable_lvl   = lvl;
            for (int k = KEY_UP; k <= KEY_DOWN; k++) begin
                change_time[k] = now;
            end
            long_done    = 1'b0;
            press_time   = '0;
            keypad_ready = 1'b1;
        end else if (keypad_ready) begin
            // Fixed priority; the first event stops the scan.
            for (int k = KEY_UP; k <= KEY_DOWN && ev == EV_NONE; k++) begin
                ev = debounce_key(k, lvl[k], now);
            end
        end
        return ev;
    endfunction

    // Follow configuration writes, predict on input transfers, compare on result transfers.
    always @(posedge aclk) begin
        logic [2:0] want;
        if (!aresetn) begin
            debounce_ms  = DEBOUNCE_AFTER_RESET;
            longpress_ms = LONGPRESS_AFTER_RESET;
            keypad_ready = 1'b0;
            sampled_lvl  = '0;
            stable_lvl   = '0;
            long_done    = 1'b0;
            press_time   = '0;
            for (int k = KEY_UP; k <= KEY_DOWN; k++) begin
                change_time[k] = '0;
            end
            owed_events.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_addr == CFG_DEBOUNCE) begin
                    debounce_ms = cfg_wdata;
                end else begin
                    longpress_ms = cfg_wdata;
                end
            end
            if (s_valid && s_ready) begin
                owed_events.push_back(qualify_item(s_func, s_now_ms,
                    {s_down_pressed, s_select_pressed, s_up_pressed}));
            end
            if (m_valid && m_ready) begin
                if (owed_events.size() == 0) begin
                    $error("key_event: no transfer expected, actual %0d", m_key_event);
                    error_count++;
                end else begin
                    want = owed_events.pop_front();
                    result_count++;
                    if (want != EV_NONE) begin
                        event_count++;
                    end
                    if (m_key_event !== want) begin
                        $error("key_event: expected %0d, actual %0d", want, m_key_event);
                        error_count++;
                    end
                end
            end
        end
        pending    <= owed_events.size();
        errors     <= error_count;
        checked    <= result_count;
        key_events <= event_count;
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import tkd_pkg::*;

    localparam logic FUNC_INIT       = 1'b0;
    localparam logic FUNC_POLL       = 1'b1;
    localparam int   CYCLE_LIMIT     = 400000;
    localparam int   DRAIN_CYCLES    = 4;
    localparam int   MAX_IDLE        = 18;
    localparam int   RANDOM_PHASES   = 6;
    localparam int   ITEMS_PER_PHASE = 250;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_func;
    logic [31:0] s_now_ms;
    logic        s_up_pressed;
    logic        s_select_pressed;
    logic        s_down_pressed;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_key_event;
    logic        cfg_we;
    logic        cfg_addr;
    logic [15:0] cfg_wdata;

    int          pending;
    int          errors;
    int          checked;
    int          key_events;

    int          cycle_count = 0;
    int          items_sent = 0;
    int          settings_used = 1;
    bit          no_idle = 1'b0;
    int          stall_left = 0;
    int          stall_draw;

    // Button levels and clock as the random sequences see them.
    time_t       clock_ms;
    logic [2:0]  held;
    logic [15:0] deb_now;
    logic [15:0] lp_now;

    three_key_debounce_longpress_top i_dut (.*);

    keypad_checker i_checker (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // Result side: after each transfer, hold ready low for a random stall.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) begin
                m_ready <= 1'b1;
            end
        end else if (m_valid && m_ready) begin
            stall_draw = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall_draw != 0) begin
                m_ready    <= 1'b0;
                stall_left <= stall_draw;
            end
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Present one item after a random gap and hold it until the transfer.
    task automatic send_item(input logic func, input time_t now, input logic [2:0] lvl);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_func           <= func;
        s_now_ms         <= now;
        s_up_pressed     <= lvl[KEY_UP];
        s_select_pressed <= lvl[KEY_SELECT];
        s_down_pressed   <= lvl[KEY_DOWN];
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Let every owed result come back and the pipeline settle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_settings(input logic [15:0] deb, input logic [15:0] lp);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_DEBOUNCE;
        cfg_wdata <= deb;
        @(posedge aclk);
        cfg_addr  <= CFG_LONGPRESS;
        cfg_wdata <= lp;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        deb_now = deb;
        lp_now  = lp;
        settings_used++;
    endtask

    // One item of a button session: the clock moves on about the debounce
    // time, now and then by a long hold, backwards or to anywhere at all.
    task automatic random_item();
        int   roll;
        logic func;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            clock_ms += $urandom_range(0, deb_now + deb_now / 2 + 2);
        end else if (roll < 85) begin
            clock_ms += $urandom_range(0, lp_now + deb_now + 2);
        end else if (roll < 92) begin
            clock_ms -= $urandom_range(0, 40);
        end else if (roll < 96) begin
            clock_ms = $urandom;
        end
        for (int k = KEY_UP; k <= KEY_DOWN; k++) begin
            if ($urandom_range(0, 7) == 0) begin
                held[k] = ~held[k];
            end
        end
        func = ($urandom_range(0, 49) == 0) ? FUNC_INIT : FUNC_POLL;
        send_item(func, clock_ms, held);
    endtask

    initial begin
        aresetn          <= 1'b0;
        s_valid          <= 1'b0;
        s_func           <= FUNC_INIT;
        s_now_ms         <= '0;
        s_up_pressed     <= 1'b0;
        s_select_pressed <= 1'b0;
        s_down_pressed   <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_addr         <= CFG_DEBOUNCE;
        cfg_wdata        <= '0;
        deb_now = 16'd50;
        lp_now  = 16'd1000;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed sequence with the default debounce and long-press times.
        // Polls ahead of init must report nothing and leave the state alone.
        send_item(FUNC_POLL, 32'hFFFF_FFFF, 3'b111);
        send_item(FUNC_POLL, 32'h0000_0000, 3'b000);
        send_item(FUNC_INIT, 32'd0, 3'b000);
        // Up press, bouncing first, then stable.
        send_item(FUNC_POLL, 32'd10, 3'b001);
        send_item(FUNC_POLL, 32'd60, 3'b001);
        // Select held into a long press, then a silent release.
        send_item(FUNC_POLL, 32'd70, 3'b011);
        send_item(FUNC_POLL, 32'd120, 3'b011);
        send_item(FUNC_POLL, 32'd1120, 3'b011);
        send_item(FUNC_POLL, 32'd1130, 3'b001);
        send_item(FUNC_POLL, 32'd1180, 3'b001);
        // Short select press reports on release.
        send_item(FUNC_POLL, 32'd1190, 3'b011);
        send_item(FUNC_POLL, 32'd1240, 3'b011);
        send_item(FUNC_POLL, 32'd1250, 3'b001);
        send_item(FUNC_POLL, 32'd1300, 3'b001);
        // Up release and down press in the same polls.
        send_item(FUNC_POLL, 32'd1310, 3'b100);
        send_item(FUNC_POLL, 32'd1360, 3'b100);
        // Up and select change together; up wins and select waits a poll.
        send_item(FUNC_POLL, 32'd1370, 3'b111);
        send_item(FUNC_POLL, 32'd1420, 3'b111);
        send_item(FUNC_POLL, 32'd1420, 3'b111);
        // A timestamp that runs backwards reads as a long elapsed time.
        send_item(FUNC_POLL, 32'd1000, 3'b110);
        // Debounce across the wrap of the millisecond counter.
        send_item(FUNC_INIT, 32'hFFFF_FFF0, 3'b111);
        send_item(FUNC_POLL, 32'h0000_0030, 3'b000);
        send_item(FUNC_POLL, 32'h0000_0062, 3'b000);
        send_item(FUNC_POLL, 32'h0000_0070, 3'b000);

        // Random sessions, each under its own timing setting.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            case (phase)
                0:       write_settings(16'd0, 16'd0);
                1:       write_settings(16'hFFFF, 16'hFFFF);
                2:       write_settings(16'd0, 16'hFFFF);
                3:       write_settings(16'hFFFF, 16'd0);
                default: write_settings(16'($urandom_range(0, 100)),
                                        16'($urandom_range(0, 800)));
            endcase
            clock_ms = $urandom;
            held     = 3'($urandom_range(0, 7));
            send_item(FUNC_INIT, clock_ms, held);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 50 == 0) begin
                    no_idle = ($urandom_range(0, 3) == 0);
                end
                random_item();
            end
        end

        wait_idle();
        $display("Covered %0d items under %0d timing settings; %0d results checked, %0d events.",
                 items_sent, settings_used, checked, key_events);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
